// File: hw/rtl/pcbd_pkg.sv
package pcbd_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ACC_W  = MAX_CODE_LEN;
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int EQ_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int ENTRY_W = CODE_W + LEN_W;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic ST_SYMBOL   = 1'b0;
    localparam logic ST_OVERFLOW = 1'b1;

    typedef struct packed {
        logic load;      // write table entry
        logic start;     // shift bit in, arm scan
        logic issue;     // read next entry
        logic res_load;  // write result register, clear accumulator
    } t_cmd;

    typedef struct packed {
        logic hit;         // entry in compare stage matches
        logic scan_end;    // lowest entry is in compare stage
        logic issued_all;  // every entry has been read
        logic at_max;      // accumulator is full
        logic out_free;    // result register can take a beat
    } t_stat;

endpackage

// File: hw/rtl/pcbd_ram.sv
module pcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pcbd_datapath.sv
module pcbd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcbd_pkg::t_cmd               i_cmd,
    input  logic [pcbd_pkg::SYM_W-1:0]   i_entry_symbol,
    input  logic [pcbd_pkg::CODE_W-1:0]  i_code_bits,
    input  logic [pcbd_pkg::LEN_W-1:0]   i_code_length,
    input  logic                         i_bit_value,
    input  logic                         i_out_stall,
    output pcbd_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output logic [pcbd_pkg::SYM_W-1:0]   o_symbol,
    output logic                         o_status
);

    logic [pcbd_pkg::ACC_W-1:0]   r_acc,  n_acc;
    logic [pcbd_pkg::CNT_W-1:0]   r_cnt,  n_cnt;
    logic [pcbd_pkg::CMP_W-1:0]   r_mask, n_mask;
    logic [pcbd_pkg::ADDR_W-1:0]  r_addr;
    logic [pcbd_pkg::ADDR_W-1:0]  r_tag;
    logic                         r_tag_vld;
    logic                         r_vld_q;
    logic                         r_issued_all;
    logic [pcbd_pkg::SYMBOL_COUNT-1:0] r_valid;
    logic                         r_out_vld;
    logic [pcbd_pkg::SYM_W-1:0]   r_out_sym;
    logic                         r_out_stat;

    logic                         wr_en;
    logic [pcbd_pkg::ADDR_W-1:0]  wr_addr;
    logic [pcbd_pkg::ENTRY_W-1:0] rd_data;
    logic [pcbd_pkg::CODE_W-1:0]  rd_code;
    logic [pcbd_pkg::LEN_W-1:0]   rd_len;
    logic                         hit;

    // out-of-range symbols are dropped
    assign wr_en   = i_cmd.load && (32'(i_entry_symbol) < pcbd_pkg::SYMBOL_COUNT);
    assign wr_addr = pcbd_pkg::ADDR_W'(i_entry_symbol);

    pcbd_ram #(
        .WIDTH (pcbd_pkg::ENTRY_W),
        .DEPTH (pcbd_pkg::SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({i_code_bits, i_code_length}),
        .i_re    (i_cmd.issue),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_code = rd_data[pcbd_pkg::ENTRY_W-1:pcbd_pkg::LEN_W];
    assign rd_len  = rd_data[pcbd_pkg::LEN_W-1:0];

    assign n_acc = pcbd_pkg::ACC_W'({r_acc, i_bit_value});
    assign n_cnt = r_cnt + pcbd_pkg::CNT_W'(1);

    always_comb begin
        for (int k = 0; k < pcbd_pkg::CMP_W; k++) begin
            n_mask[k] = (k < int'(n_cnt));
        end
    end

    // unwritten entries read as unused
    assign hit = r_tag_vld && r_vld_q && (rd_len != '0)
              && (pcbd_pkg::EQ_W'(rd_len) == pcbd_pkg::EQ_W'(r_cnt))
              && ((pcbd_pkg::CMP_W'(rd_code) & r_mask) == pcbd_pkg::CMP_W'(r_acc));

    assign o_stat.hit        = hit;
    assign o_stat.scan_end   = r_tag_vld && (r_tag == '0);
    assign o_stat.issued_all = r_issued_all;
    assign o_stat.at_max     = (r_cnt == pcbd_pkg::CNT_W'(pcbd_pkg::MAX_CODE_LEN));
    assign o_stat.out_free   = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_cnt        <= '0;
            r_tag_vld    <= 1'b0;
            r_issued_all <= 1'b0;
            r_valid      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_acc        <= n_acc;
                r_cnt        <= n_cnt;
                r_mask       <= n_mask;
                r_addr       <= pcbd_pkg::ADDR_W'(pcbd_pkg::SYMBOL_COUNT - 1);
                r_tag_vld    <= 1'b0;
                r_issued_all <= 1'b0;
            end
            if (i_cmd.issue) begin
                r_tag        <= r_addr;
                r_tag_vld    <= 1'b1;
                r_vld_q      <= r_valid[r_addr];
                r_addr       <= r_addr - pcbd_pkg::ADDR_W'(1);
                r_issued_all <= (r_addr == '0);
            end
            if (i_cmd.res_load) begin
                r_acc      <= '0;
                r_cnt      <= '0;
                r_out_vld  <= 1'b1;
                r_out_sym  <= hit ? pcbd_pkg::SYM_W'(r_tag) : '0;
                r_out_stat <= hit ? pcbd_pkg::ST_SYMBOL : pcbd_pkg::ST_OVERFLOW;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_symbol    = r_out_sym;
    assign o_status    = r_out_stat;

endmodule

// File: hw/rtl/pcbd_ctrl.sv
module pcbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_op,
    input  pcbd_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output pcbd_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == pcbd_pkg::OP_DECODE) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // descending scan: first hit is the highest symbol
                if (i_stat.hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.scan_end) begin
                    if (!i_stat.at_max) begin
                        n_state = S_IDLE;
                    end else if (i_stat.out_free) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (!i_stat.issued_all) begin
                    o_cmd.issue = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: hw/rtl/prefix_code_bit_decoder.sv
// Prefix-code decoder with a loadable code table, one compressed bit a beat.
//
// Input channel (i_in_valid / o_in_stall): a beat with i_op = load writes
// the table entry of i_entry_symbol (pattern and length, length 0 = unused)
// and does not stall the input. A beat with i_op = decode shifts i_bit_value into
// the accumulator and starts a scan of the table.
// The scan reads one entry a cycle from the table RAM, highest symbol first,
// and stops at the first exact match of pattern and length. A decode beat
// therefore holds the input until the scan ends, at a hit or at the lowest
// entry, and longer while a finished result waits for a free output register;
// the single table read port sets the pace. Throughput is one decode beat per scan.
// Output channel (o_out_valid / i_out_stall): one result beat per matched
// code (status 0) or per full accumulator without match (status 1,
// symbol 0). The result sits in an output register, so new input beats are
// taken while it waits; a scan that finishes under stall holds until the
// register frees up.
// Reset (synchronous, active low) empties the table through per-entry valid
// flops and clears the accumulator at once; no clearing pass is needed.
module prefix_code_bit_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [pcbd_pkg::SYM_W-1:0]   i_entry_symbol,
    input  logic [pcbd_pkg::CODE_W-1:0]  i_code_bits,
    input  logic [pcbd_pkg::LEN_W-1:0]   i_code_length,
    input  logic                         i_bit_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [pcbd_pkg::SYM_W-1:0]   o_symbol,
    output logic                         o_status
);

    pcbd_pkg::t_cmd  cmd;
    pcbd_pkg::t_stat stat;

    // sequencing: idle / scan
    pcbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // table RAM, accumulator, compare stage and result register
    pcbd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_entry_symbol (i_entry_symbol),
        .i_code_bits    (i_code_bits),
        .i_code_length  (i_code_length),
        .i_bit_value    (i_bit_value),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_symbol       (o_symbol),
        .o_status       (o_status)
    );

endmodule

// File: hw/rtl/pcbd_checker.sv
module pcbd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_op,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [pcbd_pkg::SYM_W-1:0]   o_symbol,
    input logic                         o_status
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_symbol)
                                        && $stable(o_status))
        else $error("result beat changed under stall");

    // overflow carries symbol zero
    a_ovf_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == pcbd_pkg::ST_OVERFLOW) |-> (o_symbol == '0))
        else $error("overflow beat with nonzero symbol");

    // a decode beat always starts a scan
    a_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_op == pcbd_pkg::OP_DECODE) |=> o_in_stall)
        else $error("decode beat did not start a scan");

    // a load beat never blocks the next one
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_op == pcbd_pkg::OP_LOAD) |=> !o_in_stall)
        else $error("load beat stalled input");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

endmodule

bind prefix_code_bit_decoder pcbd_checker u_pcbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_symbol    (o_symbol),
    .o_status    (o_status)
);

// File: dv/prefix_code_bit_decoder_test.sv
module prefix_code_bit_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int ITEMS      = 950;
    localparam int TAIL_BEATS = 100;            // last stretch runs without idling
    localparam int LONG_HOLD  = 2500;           // one long receiver hold-off, in cycles
    localparam int SETTLE     = pcbd_pkg::SYMBOL_COUNT + 40;

    // One input beat as it sits in the send queue
    typedef struct {
        logic                        op;
        logic [pcbd_pkg::SYM_W-1:0]  sym;
        logic [pcbd_pkg::CODE_W-1:0] code;
        logic [pcbd_pkg::LEN_W-1:0]  len;
        logic                        bitv;
        bit                          after_drain;   // sender waits for every due result first
    } t_beat;

    // One result beat
    typedef struct packed {
        logic [pcbd_pkg::SYM_W-1:0] sym;
        logic                       status;
    } t_decoded;

    // Clock, reset and block ports; every input known from time zero
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic                          i_op           = pcbd_pkg::OP_LOAD;
    logic [pcbd_pkg::SYM_W-1:0]    i_entry_symbol = '0;
    logic [pcbd_pkg::CODE_W-1:0]   i_code_bits    = '0;
    logic [pcbd_pkg::LEN_W-1:0]    i_code_length  = '0;
    logic                          i_bit_value    = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic [pcbd_pkg::SYM_W-1:0]    o_symbol;
    logic                          o_status;

    prefix_code_bit_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_entry_symbol (i_entry_symbol),
        .i_code_bits    (i_code_bits),
        .i_code_length  (i_code_length),
        .i_bit_value    (i_bit_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_symbol       (o_symbol),
        .o_status       (o_status)
    );

    // Our own picture of the decoder: code table plus bit accumulator
    logic [pcbd_pkg::CODE_W-1:0] tab_code [pcbd_pkg::SYMBOL_COUNT];
    logic [pcbd_pkg::LEN_W-1:0]  tab_len  [pcbd_pkg::SYMBOL_COUNT];
    logic [pcbd_pkg::ACC_W-1:0]  acc_word;
    int                          acc_n;

    // Results owed by the block, oldest first
    t_decoded symbols_due [$];

    // Stimulus
    t_beat             beats_to_send [$];
    t_beat             cur_beat = '{default: 0};
    int                beats_queued;
    bit                drain_next;

    // Generator's view of the current phase's prefix code
    logic [pcbd_pkg::CODE_W-1:0] gen_pat [pcbd_pkg::SYMBOL_COUNT];
    int                          gen_len [pcbd_pkg::SYMBOL_COUNT];
    int                          gen_syms [$];
    int                          spare_sym;
    logic [pcbd_pkg::CODE_W-1:0] hole_pat;
    int                          hole_len;

    // Bookkeeping
    int  loads_taken;
    int  bits_taken;
    int  symbols_seen;
    int  overflows_seen;
    int  mismatches;
    bit  feed_finished;
    bit  tail_phase;

    // Clock and the one reset at the start
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one accepted beat to the table model. A load rewrites an entry
    // and owes nothing; a decode bit shifts in, then every used entry whose
    // length equals the bit count and whose low bits equal the accumulator
    // is a hit, the highest symbol winning. A full accumulator with no hit
    // owes an overflow beat with symbol 0.
    task automatic decode_or_load(input t_beat b);
        int          hit;
        logic [63:0] mask;
        t_decoded    owed;
        if (b.op == pcbd_pkg::OP_LOAD) begin
            if (int'(b.sym) < pcbd_pkg::SYMBOL_COUNT) begin
                tab_code[b.sym] = b.code;
                tab_len[b.sym]  = b.len;
            end
            loads_taken++;
            return;
        end
        bits_taken++;
        acc_word = {acc_word[pcbd_pkg::ACC_W-2:0], b.bitv};
        acc_n++;
        hit = -1;
        for (int s = 0; s < pcbd_pkg::SYMBOL_COUNT; s++) begin
            mask = (64'd1 << tab_len[s]) - 64'd1;
            if (tab_len[s] != 0 && int'(tab_len[s]) == acc_n &&
                (({32'd0, tab_code[s]} & mask) == 64'(acc_word)))
                hit = s;
        end
        if (hit >= 0) begin
            owed.sym    = hit[pcbd_pkg::SYM_W-1:0];
            owed.status = pcbd_pkg::ST_SYMBOL;
        end else if (acc_n >= pcbd_pkg::MAX_CODE_LEN) begin
            owed.sym    = '0;
            owed.status = pcbd_pkg::ST_OVERFLOW;
        end else begin
            return;
        end
        symbols_due.push_back(owed);
        acc_word = '0;
        acc_n    = 0;
    endtask

    task automatic queue_beat(logic op, int sym, logic [pcbd_pkg::CODE_W-1:0] code, int len,
                              logic bitv);
        t_beat b;
        b.op          = op;
        b.sym         = sym[pcbd_pkg::SYM_W-1:0];
        b.code        = code;
        b.len         = len[pcbd_pkg::LEN_W-1:0];
        b.bitv        = bitv;
        b.after_drain = drain_next;
        drain_next    = 1'b0;
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    // Unused fields carry random noise
    task automatic queue_load(int sym, logic [pcbd_pkg::CODE_W-1:0] code, int len);
        queue_beat(pcbd_pkg::OP_LOAD, sym, code, len, $urandom_range(0, 1));
    endtask

    task automatic queue_bit(logic b);
        queue_beat(pcbd_pkg::OP_DECODE, $urandom_range(0, 255), $urandom,
                   $urandom_range(0, 63), b);
    endtask

    // Send one code word, first bit most significant; now and then a load of
    // a never-matching entry lands between its bits.
    task automatic queue_word(int sym);
        for (int k = gen_len[sym] - 1; k >= 0; k--) begin
            queue_bit(gen_pat[sym][k]);
            if ($urandom_range(0, 39) == 0)
                queue_load(spare_sym, $urandom, $urandom_range(pcbd_pkg::MAX_CODE_LEN + 1, 63));
        end
    endtask

    // Clear last phase's entries, grow a random full binary tree of up to n leaves
    // and load it under random symbols. A chain tree first drives one branch
    // down to the full code length. With a hole, one leaf stays unloaded so
    // that its path can only end in overflow.
    task automatic build_code(int n, int depth_cap, bit chain, bit hole);
        logic [pcbd_pkg::CODE_W-1:0] pat [$];
        int                          len [$];
        int                          pool [pcbd_pkg::SYMBOL_COUNT];
        int                          pick, tries, j, tmp, hole_idx, dup;
        logic [pcbd_pkg::CODE_W-1:0] hi;
        foreach (gen_syms[k])
            queue_load(gen_syms[k], $urandom, 0);
        gen_syms.delete();
        pat = '{32'd0, 32'd1};
        len = '{1, 1};
        while (pat.size() < n) begin
            if (chain && len[len.size()-1] < pcbd_pkg::MAX_CODE_LEN) begin
                pick = len.size() - 1;
            end else begin
                pick  = $urandom_range(0, pat.size() - 1);
                tries = 0;
                while (len[pick] >= depth_cap && tries < 50) begin
                    pick = $urandom_range(0, pat.size() - 1);
                    tries++;
                end
                if (len[pick] >= depth_cap)
                    break;
            end
            pat.push_back({pat[pick][pcbd_pkg::CODE_W-2:0], 1'b1});
            len.push_back(len[pick] + 1);
            pat[pick] = {pat[pick][pcbd_pkg::CODE_W-2:0], 1'b0};
            len[pick]++;
        end
        for (int k = 0; k < pcbd_pkg::SYMBOL_COUNT; k++)
            pool[k] = k;
        for (int k = 0; k < pat.size() + 2; k++) begin
            j       = $urandom_range(k, pcbd_pkg::SYMBOL_COUNT - 1);
            tmp     = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
        end
        hole_idx  = hole ? $urandom_range(0, pat.size() - 1) : -1;
        spare_sym = pool[pat.size()];
        for (int k = 0; k < pat.size(); k++) begin
            if (k == hole_idx) begin
                hole_pat = pat[k];
                hole_len = len[k];
                continue;
            end
            hi = $urandom;
            gen_pat[pool[k]] = pat[k];
            gen_len[pool[k]] = len[k];
            gen_syms.push_back(pool[k]);
            // junk above the code length must not take part in the match
            queue_load(pool[k],
                       (len[k] >= pcbd_pkg::CODE_W) ? pat[k] : ((hi << len[k]) | pat[k]),
                       len[k]);
        end
        // sometimes a second symbol with the same code: the higher one wins
        if (!hole && $urandom_range(0, 2) == 0) begin
            dup = pool[$urandom_range(0, pat.size() - 1)];
            gen_pat[pool[pat.size()+1]] = gen_pat[dup];
            gen_len[pool[pat.size()+1]] = gen_len[dup];
            gen_syms.push_back(pool[pat.size()+1]);
            queue_load(pool[pat.size()+1], gen_pat[dup], gen_len[dup]);
        end
        if ($urandom_range(0, 1) == 0)
            queue_load(spare_sym, $urandom, $urandom_range(pcbd_pkg::MAX_CODE_LEN + 1, 63));
    endtask

    // Stimulus: whole run queued at time zero
    initial begin
        int  phase;
        int  nwords;
        bit  hole;
        bit  chain;
        for (int s = 0; s < pcbd_pkg::SYMBOL_COUNT; s++) begin
            tab_code[s] = '0;
            tab_len[s]  = '0;
            gen_pat[s]  = '0;
            gen_len[s]  = 0;
        end
        acc_word = '0;
        acc_n    = 0;

        // Directed part
        queue_load(0,   32'h0000_0000, 2);          // "00", lowest symbol
        queue_load(5,   32'hFFFF_FFFD, 2);          // "01" with junk above the length
        queue_load(10,  32'h0000_0001, 2);          // "01" again: symbol 10 beats 5
        queue_load(255, 32'hFFFF_FFFF, 33);         // longer than the accumulator
        queue_load(254, 32'h0000_0000, 63);         // longest length field, never hits
        queue_load(100, 32'h0000_0003, 2);          // "11"
        queue_load(201, 32'h0000_0002, 2);          // "10", then emptied again
        queue_load(201, 32'hAAAA_5555, 0);
        queue_load(1,   32'h8000_0001, 32);         // full-width code
        queue_load(128, 32'h5555_AAAA, 0);          // length 0 with a non-zero pattern
        queue_bit(1'b0); queue_bit(1'b0);           // symbol 0
        queue_bit(1'b0); queue_bit(1'b1);           // symbol 10
        queue_bit(1'b1); queue_bit(1'b1);           // symbol 100
        queue_bit(1'b1);
        queue_load(200, 32'h0000_0002, 2);          // load between two bits of a word
        queue_bit(1'b0);                            // symbol 200, 201 now unused
        gen_syms = '{0, 5, 10, 100, 200, 1};

        // Random part: phases of fresh prefix codes
        phase = 0;
        while (beats_queued < ITEMS) begin
            hole       = (phase % 3 == 1);
            chain      = (phase == 3);
            drain_next = (phase % 4 == 2);
            build_code(chain ? pcbd_pkg::MAX_CODE_LEN + 2 : $urandom_range(2, 24),
                       chain ? pcbd_pkg::MAX_CODE_LEN : 10, chain, hole);
            if (chain) begin
                foreach (gen_syms[k])
                    if (gen_len[gen_syms[k]] == pcbd_pkg::MAX_CODE_LEN)
                        queue_word(gen_syms[k]);
            end
            nwords = $urandom_range(8, 30);
            repeat (nwords) begin
                if (!hole && $urandom_range(0, 11) == 0)
                    repeat ($urandom_range(1, 3)) queue_bit($urandom_range(0, 1));
                else
                    queue_word(gen_syms[$urandom_range(0, gen_syms.size() - 1)]);
            end
            if (hole) begin
                // down the missing branch and on until the accumulator is full
                for (int k = hole_len - 1; k >= 0; k--)
                    queue_bit(hole_pat[k]);
                for (int k = hole_len; k < pcbd_pkg::MAX_CODE_LEN; k++)
                    queue_bit($urandom_range(0, 1));
            end
            phase++;
        end
    end

    // Sender: one beat held until taken; random idle bursts after a beat,
    // calm windows, and a pause until all owed results are in where asked.
    int tx_cycle;
    int gap_left;

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            tx_cycle++;
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                decode_or_load(cur_beat);
                next_valid = 1'b0;
                if (!tail_phase && (tx_cycle / 1500) % 4 != 1 && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 12);
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (beats_to_send.size() > 0 &&
                             (!beats_to_send[0].after_drain || symbols_due.size() == 0)) begin
                    cur_beat   = beats_to_send.pop_front();
                    next_valid = 1'b1;
                end
            end
            tail_phase = (beats_to_send.size() < TAIL_BEATS);
            if (!next_valid && beats_to_send.size() == 0)
                feed_finished = 1'b1;
            i_in_valid     <= next_valid;
            i_op           <= cur_beat.op;
            i_entry_symbol <= cur_beat.sym;
            i_code_bits    <= cur_beat.code;
            i_code_length  <= cur_beat.len;
            i_bit_value    <= cur_beat.bitv;
        end
    end

    // Receiver stall: one long hold-off once results flow, so the output
    // register fills and the block backs up onto its input; otherwise random
    // bursts with calm windows, none in the tail.
    int  rx_cycle;
    int  hold_left;
    int  burst_left;
    bit  hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && symbols_seen >= 20) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (!tail_phase && (rx_cycle / 1500) % 4 != 3 &&
                         $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic log_mismatch(string why, t_decoded want, t_decoded got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch %0d at %0t: %s: expected symbol %0d status %0d, ",
                      "got symbol %0d status %0d"},
                     mismatches, $time, why, want.sym, want.status, got.sym, got.status);
    endtask

    // Result side: each taken beat against the oldest owed result
    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.sym    = o_symbol;
            got.status = o_status;
            if (got.status == pcbd_pkg::ST_OVERFLOW)
                overflows_seen++;
            else
                symbols_seen++;
            if (symbols_due.size() == 0) begin
                log_mismatch("result with nothing owed", '0, got);
            end else begin
                want = symbols_due.pop_front();
                if (got.sym !== want.sym)
                    log_mismatch("symbol", want, got);
                else if (got.status !== want.status)
                    log_mismatch("status", want, got);
            end
        end
    end

    // End of run: everything sent, everything owed arrived, one scan to settle
    initial begin
        @(posedge i_rst_n);
        while (!feed_finished) @(posedge i_clk);
        while (symbols_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d table loads and %0d coded bits over random prefix codes",
                 loads_taken, bits_taken);
        $display("decoded %0d symbols, %0d overflow beats, %0d bad beats",
                 symbols_seen, overflows_seen, mismatches);
        if (mismatches == 0 && symbols_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, several times the slowest clean run
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/pcbd_pkg.sv
hw/rtl/pcbd_ram.sv
hw/rtl/pcbd_datapath.sv
hw/rtl/pcbd_ctrl.sv
hw/rtl/prefix_code_bit_decoder.sv
hw/rtl/pcbd_checker.sv
dv/prefix_code_bit_decoder_test.sv
